// File: rtl/core/nnc_pkg.sv
// Types, constants and helpers shared by the nearest neighbour classifier.
`default_nettype none
package nnc_pkg;

  localparam int TABLE_DEPTH  = 256;
  localparam int NUM_FEATURES = 4;
  localparam int IN_FEATS     = 4;

  localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int PAIR_N = (NUM_FEATURES + 1) / 2;
  localparam int SUM_W  = 65 + $clog2(PAIR_N);

  localparam logic [1:0] REQ_CLEAR  = 2'd0;
  localparam logic [1:0] REQ_APPEND = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_NO_MATCH = 2'd2
  } status_e;

  typedef logic signed [31:0] feat_t;
  typedef feat_t [NUM_FEATURES-1:0] feat_vec_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [15:0]        class_label;
    logic signed [31:0] feat_area;
    logic signed [31:0] feat_fill;
    logic signed [31:0] feat_aspect;
    logic signed [31:0] feat_angle;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] best_label;
    logic [63:0] best_distance;
    logic [8:0]  table_count;
  } out_item_t;

  typedef struct packed {
    logic [15:0] label;
    feat_vec_t   feat;
  } entry_t;

  // tag travelling alongside an entry through the distance pipeline
  typedef struct packed {
    logic        vld;
    logic        first;
    logic        last;
    logic [15:0] label;
  } dist_tag_t;

  function automatic feat_vec_t to_feat_vec(input in_item_t item);
    feat_vec_t v;
    for (int i = 0; i < NUM_FEATURES; i++) begin
      v[i] = '0;
      if (i < IN_FEATS) begin
        case (i)
          0:       v[i] = item.feat_area;
          1:       v[i] = item.feat_fill;
          2:       v[i] = item.feat_aspect;
          3:       v[i] = item.feat_angle;
          default: v[i] = '0;
        endcase
      end
    end
    return v;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/nnc_cell.sv
// One reference table cell: holds an entry, loads on append, passes it on when rotating.
`default_nettype none
module nnc_cell
  import nnc_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   shift_i,
  input  wire logic   load_i,
  input  wire entry_t load_data_i,
  input  wire entry_t nbr_i,
  output entry_t      entry_o
);

  entry_t entry_q, entry_d;

  always_comb begin
    entry_d = entry_q;
    if (shift_i) begin
      entry_d = nbr_i;
    end else if (load_i) begin
      entry_d = load_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule
`default_nettype wire

// File: rtl/core/nnc_dist.sv
// Four-stage squared Euclidean distance pipeline with 64-bit saturation.
`default_nettype none
module nnc_dist
  import nnc_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire dist_tag_t tag_i,
  input  wire feat_vec_t query_i,
  input  wire feat_vec_t ref_i,
  output dist_tag_t      tag_o,
  output logic [63:0]    dist_o
);

  dist_tag_t tag1_q, tag2_q, tag3_q, tag4_q;

  logic [31:0]      abs_d [NUM_FEATURES];
  logic [31:0]      abs_q [NUM_FEATURES];
  logic [63:0]      sq_d  [2*PAIR_N];
  logic [63:0]      sq_q  [2*PAIR_N];
  logic [64:0]      pair_d [PAIR_N];
  logic [64:0]      pair_q [PAIR_N];
  logic [SUM_W-1:0] total;
  logic [63:0]      dist_d, dist_q;

  always_comb begin
    logic signed [32:0] diff;
    for (int i = 0; i < NUM_FEATURES; i++) begin
      diff     = {query_i[i][31], query_i[i]} - {ref_i[i][31], ref_i[i]};
      abs_d[i] = diff[32] ? 32'(-diff) : diff[31:0];
    end
  end

  always_comb begin
    for (int i = 0; i < 2*PAIR_N; i++) begin
      sq_d[i] = '0;
      if (i < NUM_FEATURES) begin
        sq_d[i] = {32'd0, abs_q[i]} * {32'd0, abs_q[i]};
      end
    end
  end

  always_comb begin
    for (int p = 0; p < PAIR_N; p++) begin
      pair_d[p] = {1'b0, sq_q[2*p]} + {1'b0, sq_q[2*p+1]};
    end
  end

  always_comb begin
    total = '0;
    for (int p = 0; p < PAIR_N; p++) begin
      total = total + SUM_W'(pair_q[p]);
    end
    dist_d = (|total[SUM_W-1:64]) ? '1 : total[63:0];
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NUM_FEATURES; i++) begin
      abs_q[i] <= abs_d[i];
    end
    for (int i = 0; i < 2*PAIR_N; i++) begin
      sq_q[i] <= sq_d[i];
    end
    for (int p = 0; p < PAIR_N; p++) begin
      pair_q[p] <= pair_d[p];
    end
    dist_q <= dist_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
      tag2_q <= '0;
      tag3_q <= '0;
      tag4_q <= '0;
    end else begin
      tag1_q <= tag_i;
      tag2_q <= tag1_q;
      tag3_q <= tag2_q;
      tag4_q <= tag3_q;
    end
  end

  assign tag_o  = tag4_q;
  assign dist_o = dist_q;

endmodule
`default_nettype wire

// File: rtl/core/nearest_neighbor_classifier_top.sv
// Top level of the one-nearest-neighbour classifier: cell ring, scan control, result register.
//
// Usage: one request word in on in_data_i (valid/stall), one result word out on
// out_data_o (valid/stall) for every request. req_type selects clear, append or
// query. Clear and append answer one cycle after acceptance. An append to a full
// table is dropped with status full.
// The reference table is a ring of TABLE_DEPTH cells. A query rotates the whole
// ring once, one entry per cycle past cell 0, into a four-stage distance pipeline
// followed by the best-so-far compare; the result is registered once the last
// valid entry leaves the pipeline and the result register is free.
// A query on an empty table answers at once with status no_match.
// Only one request is in work at a time; a query to a non-empty table may be
// accepted while the previous result waits to be taken, others wait for the result register.
// Reset empties the table (count zero) and drops any result in flight; the
// table contents are not cleared. A stalled result holds on out_data_o and
// the finished query waits until it is taken.
`default_nettype none
module nearest_neighbor_classifier_top
  import nnc_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire in_item_t in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output out_item_t     out_data_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [IDX_W-1:0] scan_idx_q, scan_idx_d;
  logic [CNT_W-1:0] entry_count_q, entry_count_d;
  feat_vec_t        query_q;
  logic [63:0]      best_dist_q;
  logic [15:0]      best_label_q;
  logic             res_ready_q, res_ready_d;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_q, out_d;

  logic   in_fire, slot_free, is_query, empty, scan_start, imm_fire;
  logic   append_fire, rot_last, done_fire, shifting;
  entry_t new_entry;
  entry_t ring [TABLE_DEPTH];

  dist_tag_t tag_in, tag_out;
  logic [63:0] cur_dist;
  logic        take_best;

  assign slot_free  = !out_valid_q || !out_stall_i;
  assign is_query   = (in_data_i.req_type == REQ_QUERY);
  assign empty      = (entry_count_q == '0);
  assign in_stall_o = (state_q != S_IDLE) || (!slot_free && !(is_query && !empty));
  assign in_fire    = in_valid_i && !in_stall_o;
  assign scan_start = in_fire && is_query && !empty;
  assign imm_fire   = in_fire && !scan_start;
  assign append_fire = in_fire && (in_data_i.req_type == REQ_APPEND) &&
                       (entry_count_q < CNT_W'(TABLE_DEPTH));
  assign rot_last   = (scan_idx_q == IDX_W'(TABLE_DEPTH - 1));
  assign done_fire  = (state_q == S_WAIT) && res_ready_q && slot_free;
  assign shifting   = (state_q == S_SCAN);

  assign new_entry.label = in_data_i.class_label;
  assign new_entry.feat  = to_feat_vec(in_data_i);

  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
    nnc_cell u_cell (
      .clk_i       (clk_i),
      .shift_i     (shifting),
      .load_i      (append_fire && (entry_count_q == CNT_W'(k))),
      .load_data_i (new_entry),
      .nbr_i       (ring[(k + 1) % TABLE_DEPTH]),
      .entry_o     (ring[k])
    );
  end

  assign tag_in.vld   = shifting && (CNT_W'(scan_idx_q) < entry_count_q);
  assign tag_in.first = (scan_idx_q == '0);
  assign tag_in.last  = (CNT_W'(scan_idx_q) == entry_count_q - CNT_W'(1));
  assign tag_in.label = ring[0].label;

  nnc_dist u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tag_i   (tag_in),
    .query_i (query_q),
    .ref_i   (ring[0].feat),
    .tag_o   (tag_out),
    .dist_o  (cur_dist)
  );

  assign take_best = tag_out.vld && (tag_out.first || (cur_dist < best_dist_q));

  always_comb begin
    state_d    = state_q;
    scan_idx_d = scan_idx_q;
    case (state_q)
      S_IDLE: begin
        scan_idx_d = '0;
        if (scan_start) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        scan_idx_d = scan_idx_q + IDX_W'(1);
        if (rot_last) begin
          scan_idx_d = '0;
          state_d    = S_WAIT;
        end
      end
      S_WAIT: begin
        if (done_fire) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d    = S_IDLE;
        scan_idx_d = '0;
      end
    endcase
  end

  always_comb begin
    res_ready_d = res_ready_q;
    if (done_fire) begin
      res_ready_d = 1'b0;
    end else if (tag_out.vld && tag_out.last) begin
      res_ready_d = 1'b1;
    end
  end

  always_comb begin
    entry_count_d = entry_count_q;
    if (in_fire && (in_data_i.req_type == REQ_CLEAR)) begin
      entry_count_d = '0;
    end else if (append_fire) begin
      entry_count_d = entry_count_q + CNT_W'(1);
    end
  end

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (imm_fire) begin
      out_valid_d         = 1'b1;
      out_d.status        = STAT_OK;
      out_d.best_label    = '0;
      out_d.best_distance = '0;
      out_d.table_count   = 9'(entry_count_d);
      if (in_data_i.req_type == REQ_APPEND && !append_fire) begin
        out_d.status = STAT_FULL;
      end else if (is_query) begin
        out_d.status = STAT_NO_MATCH;
      end
    end else if (done_fire) begin
      out_valid_d         = 1'b1;
      out_d.status        = STAT_OK;
      out_d.best_label    = best_label_q;
      out_d.best_distance = best_dist_q;
      out_d.table_count   = 9'(entry_count_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      scan_idx_q    <= '0;
      entry_count_q <= '0;
      res_ready_q   <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      scan_idx_q    <= scan_idx_d;
      entry_count_q <= entry_count_d;
      res_ready_q   <= res_ready_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (scan_start) begin
      query_q <= new_entry.feat;
    end
    if (take_best) begin
      best_dist_q  <= cur_dist;
      best_label_q <= tag_out.label;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    entry_count_q <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_ring_home : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> scan_idx_q == '0)
    else $error("ring not at home position while idle");

  a_ready_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_ready_q |-> state_q != S_IDLE)
    else $error("query result pending while idle");

  a_no_append_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    shifting |-> !append_fire)
    else $error("append during ring rotation");

  a_done_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_fire |=> out_valid_q && state_q == S_IDLE)
    else $error("query result not presented");

endmodule
`default_nettype wire
